// ----- hdl/polybius_square_char_cipher_defines.svh -----
// assertion macros for the polybius square character cipher checker
// expects signals clk and rst in the scope of use
`ifndef POLYBIUS_SQUARE_CHAR_CIPHER_DEFINES_SVH
`define POLYBIUS_SQUARE_CHAR_CIPHER_DEFINES_SVH

// checked only outside reset
`define PSQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked also during reset
`define PSQ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/psq_pkg.sv -----
// shared types, constants and square tables for the polybius cipher
// no dependencies
`timescale 1ns / 1ps

package psq_pkg;

  localparam logic [7:0] NEWLINE     = 8'd10;
  localparam logic [7:0] CASE_OFFSET = 8'd32;
  localparam logic [5:0] SQ_SIZE     = 6'd36;
  localparam logic [5:0] SQ_SIDE     = 6'd6;
  localparam logic [2:0] NO_LABEL    = 3'd6;

  // configuration register indexes
  localparam logic REG_KEY  = 1'b0;
  localparam logic REG_MODE = 1'b1;

  typedef struct packed {
    logic [1:0] count;        // number of results, 0 to 2
    logic [7:0] char0;
    logic       nf0;
    logic [7:0] char1;
    logic       have_first;   // next pairing state
    logic [2:0] pending_row;
  } psq_res_t;

  // symbol at position idx of the unrotated alphabet
  function automatic logic [7:0] alphabet_at(input logic [5:0] idx);
    logic [7:0] r;
    if (idx < 6'd26) begin
      r = 8'h41 + {2'b00, idx};
    end else if (idx == 6'd26) begin
      r = 8'h20;
    end else if (idx < SQ_SIZE) begin
      r = 8'h31 + {2'b00, idx - 6'd27};
    end else begin
      r = 8'h00;
    end
    return r;
  endfunction

  // position of c in the alphabet, SQ_SIZE if absent
  function automatic logic [5:0] find_alpha(input logic [7:0] c);
    logic [7:0] d;
    logic [5:0] r;
    d = 8'h00;
    if (c >= 8'h41 && c <= 8'h5a) begin
      d = c - 8'h41;
      r = d[5:0];
    end else if (c == 8'h20) begin
      r = 6'd26;
    end else if (c >= 8'h31 && c <= 8'h39) begin
      d = c - 8'h31 + 8'd27;
      r = d[5:0];
    end else begin
      r = SQ_SIZE;
    end
    return r;
  endfunction

  function automatic logic [7:0] row_label(input logic [2:0] i);
    logic [7:0] r;
    unique case (i)
      3'd0:    r = 8'h4e; // N
      3'd1:    r = 8'h4f; // O
      3'd2:    r = 8'h52; // R
      3'd3:    r = 8'h4d; // M
      3'd4:    r = 8'h41; // A
      3'd5:    r = 8'h4c; // L
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] col_label(input logic [2:0] i);
    logic [7:0] r;
    unique case (i)
      3'd0:    r = 8'h58; // X
      3'd1:    r = 8'h49; // I
      3'd2:    r = 8'h46; // F
      3'd3:    r = 8'h52; // R
      3'd4:    r = 8'h41; // A
      3'd5:    r = 8'h54; // T
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] find_row(input logic [7:0] c);
    logic [2:0] r;
    unique case (c)
      8'h4e:   r = 3'd0;
      8'h4f:   r = 3'd1;
      8'h52:   r = 3'd2;
      8'h4d:   r = 3'd3;
      8'h41:   r = 3'd4;
      8'h4c:   r = 3'd5;
      default: r = NO_LABEL;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] find_col(input logic [7:0] c);
    logic [2:0] r;
    unique case (c)
      8'h58:   r = 3'd0;
      8'h49:   r = 3'd1;
      8'h46:   r = 3'd2;
      8'h52:   r = 3'd3;
      8'h41:   r = 3'd4;
      8'h54:   r = 3'd5;
      default: r = NO_LABEL;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/psq_lookup.sv -----
// combinational square lookup: one character to its results and next pairing state
// depends on psq_pkg
`timescale 1ns / 1ps

module psq_lookup (
  input  logic [7:0]       ch,
  input  logic [5:0]       key,
  input  logic             decrypt_mode,
  input  logic             have_first,
  input  logic [2:0]       pending_row,
  output psq_pkg::psq_res_t res
);

  logic [7:0]  c_fold;
  logic [5:0]  start;
  logic [5:0]  p;
  logic [5:0]  idx;
  logic [11:0] prod;
  logic [2:0]  enc_row;
  logic [5:0]  enc_col;
  logic [2:0]  dec_col;
  logic [5:0]  cell_idx;
  logic [6:0]  sum;
  logic [6:0]  sym_wide;

  assign c_fold = (ch >= 8'h61 && ch <= 8'h7a) ? ch - psq_pkg::CASE_OFFSET : ch;
  assign start  = (key >= psq_pkg::SQ_SIZE) ? key - psq_pkg::SQ_SIZE : key;

  // encrypt path
  assign p    = psq_pkg::find_alpha(c_fold);
  assign idx  = (p >= start) ? p - start : p - start + psq_pkg::SQ_SIZE;
  // divide by six through reciprocal, exact for idx below 36
  assign prod    = {6'b0, idx} * 12'd43;
  assign enc_row = prod[10:8];
  assign enc_col = idx - {3'b0, enc_row} * psq_pkg::SQ_SIDE;

  // decrypt path
  assign dec_col  = psq_pkg::find_col(c_fold);
  assign cell_idx = {3'b0, pending_row} * psq_pkg::SQ_SIDE + {3'b0, dec_col};
  assign sum      = {1'b0, start} + {1'b0, cell_idx};
  assign sym_wide = (sum >= {1'b0, psq_pkg::SQ_SIZE}) ? sum - {1'b0, psq_pkg::SQ_SIZE} : sum;

  always_comb begin
    res.count       = 2'd0;
    res.char0       = 8'h00;
    res.nf0         = 1'b0;
    res.char1       = psq_pkg::col_label(enc_col[2:0]);
    res.have_first  = have_first;
    res.pending_row = pending_row;
    if (ch == psq_pkg::NEWLINE) begin
      res.have_first = 1'b0;
    end else if (!decrypt_mode) begin
      if (p >= psq_pkg::SQ_SIZE) begin
        res.count = 2'd1;
        res.nf0   = 1'b1;
      end else begin
        res.count = 2'd2;
        res.char0 = psq_pkg::row_label(enc_row);
      end
    end else if (!have_first) begin
      res.have_first  = 1'b1;
      res.pending_row = psq_pkg::find_row(c_fold);
    end else begin
      res.have_first = 1'b0;
      res.count      = 2'd1;
      if (pending_row >= psq_pkg::NO_LABEL || dec_col >= psq_pkg::NO_LABEL) begin
        res.nf0 = 1'b1;
      end else begin
        res.char0 = psq_pkg::alphabet_at(sym_wide[5:0]);
      end
    end
  end

endmodule

// ----- hdl/polybius_square_char_cipher.sv -----
// polybius square character cipher, 6x6 square rotated by key
// an item is held in the input register and looked up there, and its results are then registered into the result buffer
// throughput: one item per cycle with one or no result while res_stall is low; an item with results waits
// while the two-entry result buffer still holds a second result (it drains one result a cycle unless stalled)
// reset: synchronous rst clears key, mode, pairing state and all valid flags
// depends on psq_pkg and psq_lookup
`timescale 1ns / 1ps

module polybius_square_char_cipher (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [5:0] cfg_data,
  input  logic       ch_valid,
  output logic       ch_stall,
  input  logic [7:0] ch,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [7:0] out_char,
  output logic       not_found,
  output logic       last
);

  logic [5:0] key;
  logic       decrypt_mode;
  logic       have_first;
  logic [2:0] pending_row;

  logic       in_full;
  logic [7:0] in_ch;

  logic [1:0] cnt;
  logic [7:0] char0;
  logic       nf0;
  logic [7:0] char1;

  psq_pkg::psq_res_t res;
  logic out_xfer;
  logic buf_free;
  logic move;

  psq_lookup u_lookup (
    .ch           (in_ch),
    .key          (key),
    .decrypt_mode (decrypt_mode),
    .have_first   (have_first),
    .pending_row  (pending_row),
    .res          (res)
  );

  assign cfg_ready = 1'b1;
  assign res_valid = (cnt != 2'd0);
  assign out_char  = char0;
  assign not_found = nf0;
  assign last      = (cnt == 2'd1);

  assign out_xfer = res_valid && !res_stall;
  assign buf_free = (cnt == 2'd0) || (cnt == 2'd1 && out_xfer);
  // items without results pass even while the buffer is busy
  assign move     = in_full && (res.count == 2'd0 || buf_free);
  assign ch_stall = in_full && !move;

  always_ff @(posedge clk) begin
    if (rst) begin
      key          <= '0;
      decrypt_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        psq_pkg::REG_KEY:  key          <= cfg_data;
        psq_pkg::REG_MODE: decrypt_mode <= cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (ch_valid && !ch_stall) begin
      in_full <= 1'b1;
    end else if (move) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ch_valid && !ch_stall) begin
      in_ch <= ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_first  <= 1'b0;
      pending_row <= '0;
    end else if (move) begin
      have_first  <= res.have_first;
      pending_row <= res.pending_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (move && res.count != 2'd0) begin
      cnt <= res.count;
    end else if (out_xfer) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (move && res.count != 2'd0) begin
      char0 <= res.char0;
      nf0   <= res.nf0;
      char1 <= res.char1;
    end else if (out_xfer && cnt == 2'd2) begin
      // second result moves to the head
      char0 <= char1;
      nf0   <= 1'b0;
    end
  end

endmodule

// ----- hdl/psq_checker.sv -----
// port-level checker for the polybius cipher, bound to the top level
// depends on polybius_square_char_cipher_defines.svh
`timescale 1ns / 1ps
`include "polybius_square_char_cipher_defines.svh"

module psq_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_stall,
  input logic [7:0] out_char,
  input logic       not_found,
  input logic       last
);

  `PSQ_ASSERT_RST(a_reset_empty, rst |=> !res_valid, "result valid right after reset")
  `PSQ_ASSERT(a_pair_follows, (res_valid && !res_stall && !last) |=> res_valid, "second result missing")
  `PSQ_ASSERT(a_flag_char, (res_valid && not_found) |-> (out_char == 8'h00 && last), "bad flagged result")
  `PSQ_ASSERT(a_hold, (res_valid && res_stall) |=> (res_valid && $stable(out_char) && $stable(last)), "stalled result changed")

endmodule

bind polybius_square_char_cipher psq_checker u_psq_checker (.*);

// ----- sim/polybius_square_char_cipher_tb.sv -----
// self-checking testbench for the polybius square character cipher
// predicts each result in-bench and compares it with the block's output; depends on psq_pkg
`timescale 1ns / 1ps

module polybius_square_char_cipher_tb;

  localparam int SETTLE_CYCLES = 4;
  localparam int STUCK_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 60;
  localparam int MAX_REPORTS   = 40;

  typedef struct {
    logic [7:0] chr;
    logic       nf;
    logic       lst;
  } cipher_out_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = 1'b0;
  logic [5:0] cfg_data = 6'd0;
  logic       ch_valid = 1'b0;
  logic       ch_stall;
  logic [7:0] ch = 8'd0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic [7:0] out_char;
  logic       not_found;
  logic       last;

  // square contents and labels, in cell order
  string sq_symbols = "ABCDEFGHIJKLMNOPQRSTUVWXYZ 123456789";
  string row_names  = "NORMAL";
  string col_names  = "XIFRAT";

  // predictor state and configuration
  logic [5:0] m_key = 6'd0;
  logic       m_decrypt = 1'b0;
  logic [2:0] m_row = 3'd0;
  logic       m_have_first = 1'b0;

  cipher_out_t predicted_q[$];
  int err_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int stuck_cycles = 0;

  polybius_square_char_cipher dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ch_valid  (ch_valid),
    .ch_stall  (ch_stall),
    .ch        (ch),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .out_char  (out_char),
    .not_found (not_found),
    .last      (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // position of c in a table string, its length if absent
  function automatic int position_in(input string tbl, input logic [7:0] c);
    int i;
    for (i = 0; i < tbl.len(); i++) begin
      if (tbl[i] == c) begin
        return i;
      end
    end
    return tbl.len();
  endfunction

  function automatic void push_out(input logic [7:0] c, input logic nf, input logic lst);
    cipher_out_t o;
    o.chr = c;
    o.nf  = nf;
    o.lst = lst;
    predicted_q.push_back(o);
  endfunction

  // advance the predictor by one accepted character
  task automatic cipher_step(input logic [7:0] c_in);
    logic [7:0] c;
    int start;
    int p;
    int idx;
    int col;
    start = m_key % psq_pkg::SQ_SIZE;
    if (c_in == psq_pkg::NEWLINE) begin
      m_have_first = 1'b0;
      return;
    end
    c = (c_in >= "a" && c_in <= "z") ? c_in - psq_pkg::CASE_OFFSET : c_in;
    if (!m_decrypt) begin
      p = position_in(sq_symbols, c);
      if (p >= psq_pkg::SQ_SIZE) begin
        push_out(8'd0, 1'b1, 1'b1);
      end else begin
        idx = (p + psq_pkg::SQ_SIZE - start) % psq_pkg::SQ_SIZE;
        push_out(row_names[idx / psq_pkg::SQ_SIDE], 1'b0, 1'b0);
        push_out(col_names[idx % psq_pkg::SQ_SIDE], 1'b0, 1'b1);
      end
    end else if (!m_have_first) begin
      m_row = 3'(position_in(row_names, c));
      m_have_first = 1'b1;
    end else begin
      m_have_first = 1'b0;
      col = position_in(col_names, c);
      if (m_row >= psq_pkg::NO_LABEL || col >= psq_pkg::SQ_SIDE) begin
        push_out(8'd0, 1'b1, 1'b1);
      end else begin
        idx = (start + m_row * psq_pkg::SQ_SIDE + col) % psq_pkg::SQ_SIZE;
        push_out(sq_symbols[idx], 1'b0, 1'b1);
      end
    end
  endtask

  task automatic check_out();
    cipher_out_t e;
    if (predicted_q.size() == 0) begin
      err_count++;
      if (err_count <= MAX_REPORTS) begin
        $display("%0t unexpected result: char %h nf %b last %b", $time, out_char, not_found,
                 last);
      end
      return;
    end
    e = predicted_q.pop_front();
    if (out_char !== e.chr || not_found !== e.nf || last !== e.lst) begin
      err_count++;
      if (err_count <= MAX_REPORTS) begin
        $display("%0t mismatch: expected char %h nf %b last %b, got char %h nf %b last %b",
                 $time, e.chr, e.nf, e.lst, out_char, not_found, last);
      end
    end
  endtask

  // result side: check each transfer, then pick the stall for the next edge
  initial begin : result_side
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && !res_stall) begin
        check_out();
      end
      if (hold_left == 0 && hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        res_stall <= 1'b1;
        hold_left--;
      end else begin
        res_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (ch_valid && !ch_stall) || (res_valid && !res_stall)
        || (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_char(input logic [7:0] c);
    // each idle cycle before the offer drawn with the sender's idle chance
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      ch_valid <= 1'b0;
      @(posedge clk);
    end
    ch_valid <= 1'b1;
    ch <= c;
    do @(posedge clk); while (ch_stall);
    cipher_step(c);
  endtask

  task automatic wait_drained();
    ch_valid <= 1'b0;
    @(posedge clk);
    while (predicted_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [5:0] val);
    wait_drained();
    // no-result items may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == psq_pkg::REG_KEY) begin
      m_key = val;
    end else begin
      m_decrypt = val[0];
    end
  endtask

  function automatic logic [7:0] pick_label(input string names);
    logic [7:0] c;
    c = names[$urandom_range(5)];
    if ($urandom_range(99) < 30) begin
      c = c + psq_pkg::CASE_OFFSET;
    end
    return c;
  endfunction

  function automatic logic [7:0] pick_symbol();
    logic [7:0] c;
    c = sq_symbols[$urandom_range(35)];
    if (c >= "A" && c <= "Z" && $urandom_range(99) < 30) begin
      c = c + psq_pkg::CASE_OFFSET;
    end
    return c;
  endfunction

  task automatic test_encrypt_symbols();
    write_reg(psq_pkg::REG_KEY, 6'd0);
    write_reg(psq_pkg::REG_MODE, 6'd0);
    send_char("A");
    send_char("9");
    send_char(" ");
    send_char("z");
    send_char(8'h00);
    send_char(8'hff);
    send_char("{");
    send_char(psq_pkg::NEWLINE);
  endtask

  task automatic test_decrypt_pairs();
    write_reg(psq_pkg::REG_MODE, 6'd1);
    send_char("N");
    send_char("X");
    send_char("l");
    send_char("t");
    // bad row label, then bad column label
    send_char("Q");
    send_char("X");
    send_char("N");
    send_char("Q");
    // newline drops the half pair
    send_char("N");
    send_char(psq_pkg::NEWLINE);
    send_char("O");
    send_char("X");
  endtask

  task automatic test_key_wrap();
    write_reg(psq_pkg::REG_MODE, 6'd0);
    write_reg(psq_pkg::REG_KEY, 6'd35);
    send_char("A");
    write_reg(psq_pkg::REG_KEY, 6'd36);
    send_char("A");
    write_reg(psq_pkg::REG_KEY, 6'd63);
    write_reg(psq_pkg::REG_MODE, 6'd1);
    send_char("N");
    send_char("X");
  endtask

  // pending row label survives a trip through encrypt mode
  task automatic test_mode_switch_mid_pair();
    send_char("M");
    write_reg(psq_pkg::REG_MODE, 6'd0);
    send_char("B");
    write_reg(psq_pkg::REG_MODE, 6'd1);
    send_char("R");
  endtask

  task automatic test_backpressure();
    int i;
    int saved_pct;
    write_reg(psq_pkg::REG_MODE, 6'd0);
    saved_pct = tx_idle_pct;
    tx_idle_pct = 0;
    hold_requests++;
    for (i = 0; i < 24; i++) begin
      send_char(pick_symbol());
    end
    // sender stays quiet until everything has come back
    wait_drained();
    tx_idle_pct = saved_pct;
  endtask

  task automatic run_segment(input int n_items);
    int sent;
    int r;
    logic [5:0] k;
    logic [5:0] mword;
    if ($urandom_range(99) < 15) begin
      k = 6'($urandom_range(63, 36));
    end else begin
      k = 6'($urandom_range(35));
    end
    write_reg(psq_pkg::REG_KEY, k);
    mword = 6'($urandom_range(63));
    write_reg(psq_pkg::REG_MODE, mword);
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 5) begin
        send_char(psq_pkg::NEWLINE);
      end else if (r < 15) begin
        send_char(8'($urandom_range(255)));
        sent++;
      end else if (m_decrypt) begin
        send_char(pick_label(row_names));
        send_char(pick_label(col_names));
        sent += 2;
      end else begin
        send_char(pick_symbol());
        sent++;
      end
    end
  endtask

  task automatic test_random_phase(input int tx_pct, input int rx_pct, input int n_items);
    int done;
    int n;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    done = 0;
    while (done < n_items) begin
      n = $urandom_range(60, 20);
      run_segment(n);
      done += n;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 14;
    rx_idle_pct = 84;
    test_encrypt_symbols();
    test_decrypt_pairs();
    test_key_wrap();
    test_mode_switch_mid_pair();
    test_backpressure();
    test_random_phase(14, 84, 270);
    test_random_phase(84, 14, 270);
    test_random_phase(0, 0, 260);
    wait_drained();
    repeat (8) @(posedge clk);
    if (err_count == 0 && predicted_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
